// ===== hdl/pdbu_pkg.sv =====
// Shared types, action codes and bit-rearranging functions for the page display updater.
`default_nettype none
package pdbu_pkg;

    localparam logic [1:0] ACT_BLOCK = 2'd0;
    localparam logic [1:0] ACT_ICON  = 2'd1;
    localparam logic [1:0] ACT_HOME  = 2'd2;

    localparam logic [3:0] ICON_PAGE = 4'd8;

    typedef struct packed {
        logic [1:0]  action;
        logic [6:0]  block_index;
        logic [63:0] row_bytes;
        logic [3:0]  icon_index;
        logic [7:0]  icon_value;
        logic        forced;
    } pdbu_req_t;

    typedef struct packed {
        logic        send;
        logic        cursor_cmd;
        logic [3:0]  page;
        logic [6:0]  column;
        logic [63:0] column_bytes;
        logic        restore_cursor;
        logic [2:0]  restore_page;
        logic [6:0]  restore_column;
    } pdbu_rsp_t;

    // column byte l collects bit (7 - l) of every row, row r into bit r
    function automatic logic [63:0] transpose_block(input logic [63:0] rows);
        logic [63:0] res;
        res = '0;
        for (int l = 0; l < 8; l++)
        begin
            for (int r = 0; r < 8; r++)
            begin
                res[8*l + r] = rows[8*r + 7 - l];
            end
        end
        return res;
    endfunction

    // icon column j is bit (7 - j), one 0/1 byte per column
    function automatic logic [63:0] expand_icon(input logic [7:0] value);
        logic [63:0] res;
        res = '0;
        for (int j = 0; j < 8; j++)
        begin
            res[8*j] = value[7 - j];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pdbu_shadow_ram.sv =====
// Shadow store: synchronous RAM with registered read and per-entry valid bits that read as zero.
`default_nettype none
module pdbu_shadow_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 64,
    parameter int AW    = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // never-written entries hold the cleared display
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

// ===== hdl/page_display_dirty_block_updater_top.sv =====
// Top level: shadow compare, transpose and cursor tracking for a page-mode LCD.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------
//  req     | in        | req_valid / req_ready  | pdbu_req_t (request)
//  rsp     | out       | rsp_valid / rsp_ready  | pdbu_rsp_t (one per request)
//
// One request per cycle sustained while rsp_ready holds; rsp_valid comes from
// the output register behind stage 1. Stage 1 holds the shadow RAM read data;
// the read-modify-write of one entry per cycle sets the rate, with a bypass for
// back-to-back hits. Reset clears valid bits of both shadow stores at once; no
// clearing pass. A stalled response holds stage 1; req_ready drops only then.
`default_nettype none
module page_display_dirty_block_updater_top #(
    parameter int BLOCK_COUNT = 128,
    parameter int ICON_BYTES  = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire pdbu_pkg::pdbu_req_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output pdbu_pkg::pdbu_rsp_t     rsp
);
    import pdbu_pkg::*;

    localparam int BAW = $clog2(BLOCK_COUNT);
    localparam int IAW = (ICON_BYTES > 1) ? $clog2(ICON_BYTES) : 1;

    logic        req_acc;
    logic        s1_adv;
    logic [7:0]  blk_idx_in;
    logic [7:0]  blk_idx_s1;
    logic [4:0]  icn_idx_in;
    logic [4:0]  icn_idx_s1;
    logic        blk_ok_in;
    logic        icn_ok_in;

    logic [BAW-1:0] blk_rd_addr;
    logic [BAW-1:0] blk_wr_addr;
    logic [63:0]    blk_rd_data;
    logic           blk_rd_en;
    logic           blk_wr_en;
    logic [IAW-1:0] icn_rd_addr;
    logic [IAW-1:0] icn_wr_addr;
    logic [7:0]     icn_rd_data;
    logic           icn_rd_en;
    logic           icn_wr_en;

    // stage 1
    logic        s1_valid_reg;
    pdbu_req_t   s1_reg;
    logic        s1_blk_ok_reg;
    logic        s1_icn_ok_reg;
    logic        s1_byp_reg;
    logic [63:0] s1_byp_data_reg;
    logic        byp_next;
    logic [63:0] byp_data_next;

    logic [6:0]  trk_reg;
    logic [6:0]  trk_next;
    logic        trk_vld_reg;
    logic        trk_vld_next;

    logic [63:0] cur_blk;
    logic [7:0]  cur_icn;
    logic        blk_go;
    logic        icn_go;
    logic        cont;
    pdbu_rsp_t   rsp_next;

    logic        out_valid_reg;
    pdbu_rsp_t   out_reg;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_adv;
    assign req_acc   = req_valid && req_ready;

    assign blk_idx_in = {1'b0, req.block_index};
    assign blk_idx_s1 = {1'b0, s1_reg.block_index};
    assign icn_idx_in = {1'b0, req.icon_index};
    assign icn_idx_s1 = {1'b0, s1_reg.icon_index};
    assign blk_ok_in  = {1'b0, blk_idx_in} < 9'(BLOCK_COUNT);
    assign icn_ok_in  = {1'b0, icn_idx_in} < 6'(ICON_BYTES);

    assign blk_rd_addr = blk_idx_in[BAW-1:0];
    assign blk_wr_addr = blk_idx_s1[BAW-1:0];
    assign icn_rd_addr = icn_idx_in[IAW-1:0];
    assign icn_wr_addr = icn_idx_s1[IAW-1:0];

    assign blk_rd_en = req_acc && (req.action == ACT_BLOCK) && blk_ok_in;
    assign icn_rd_en = req_acc && (req.action == ACT_ICON) && icn_ok_in;

    pdbu_shadow_ram #(
        .DEPTH (BLOCK_COUNT),
        .WIDTH (64),
        .AW    (BAW)
    ) u_blk_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (blk_rd_en),
        .rd_addr (blk_rd_addr),
        .rd_data (blk_rd_data),
        .wr_en   (blk_wr_en),
        .wr_addr (blk_wr_addr),
        .wr_data (s1_reg.row_bytes)
    );

    pdbu_shadow_ram #(
        .DEPTH (ICON_BYTES),
        .WIDTH (8),
        .AW    (IAW)
    ) u_icn_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (icn_rd_en),
        .rd_addr (icn_rd_addr),
        .rd_data (icn_rd_data),
        .wr_en   (icn_wr_en),
        .wr_addr (icn_wr_addr),
        .wr_data (s1_reg.icon_value)
    );

    // a write landing on the same edge as the read of that entry is forwarded
    always_comb
    begin
        byp_next      = 1'b0;
        byp_data_next = s1_reg.row_bytes;
        if (req.action == ACT_ICON)
        begin
            byp_next      = icn_wr_en && (icn_wr_addr == icn_rd_addr);
            byp_data_next = {56'd0, s1_reg.icon_value};
        end
        else
        begin
            byp_next = blk_wr_en && (blk_wr_addr == blk_rd_addr);
        end
    end

    assign cur_blk = s1_byp_reg ? s1_byp_data_reg : blk_rd_data;
    assign cur_icn = s1_byp_reg ? s1_byp_data_reg[7:0] : icn_rd_data;

    assign blk_go = s1_valid_reg && (s1_reg.action == ACT_BLOCK) && s1_blk_ok_reg &&
                    ((cur_blk != s1_reg.row_bytes) || s1_reg.forced);
    assign icn_go = s1_valid_reg && (s1_reg.action == ACT_ICON) && s1_icn_ok_reg &&
                    ((cur_icn != s1_reg.icon_value) || s1_reg.forced);

    assign blk_wr_en = s1_adv && blk_go;
    assign icn_wr_en = s1_adv && icn_go;

    // no cursor command when the display's auto-increment already points here
    assign cont = (s1_reg.block_index[3:0] != 4'd0) && trk_vld_reg &&
                  (trk_reg == 7'(s1_reg.block_index - 7'd1));

    always_comb
    begin
        rsp_next     = '0;
        trk_next     = trk_reg;
        trk_vld_next = trk_vld_reg;
        unique case (s1_reg.action)
            ACT_BLOCK:
            begin
                if (blk_go)
                begin
                    rsp_next.send         = 1'b1;
                    rsp_next.cursor_cmd   = !cont;
                    rsp_next.page         = {1'b0, s1_reg.block_index[6:4]};
                    rsp_next.column       = {s1_reg.block_index[3:0], 3'd0};
                    rsp_next.column_bytes = transpose_block(s1_reg.row_bytes);
                    trk_next              = s1_reg.block_index;
                    trk_vld_next          = 1'b1;
                end
            end
            ACT_ICON:
            begin
                if (icn_go)
                begin
                    rsp_next.send           = 1'b1;
                    rsp_next.cursor_cmd     = 1'b1;
                    rsp_next.page           = ICON_PAGE;
                    rsp_next.column         = {s1_reg.icon_index, 3'd0};
                    rsp_next.column_bytes   = expand_icon(s1_reg.icon_value);
                    rsp_next.restore_cursor = 1'b1;
                    rsp_next.restore_page   = trk_reg[6:4];
                    rsp_next.restore_column = {trk_reg[3:0], 3'd0};
                end
            end
            ACT_HOME:
            begin
                trk_next     = 7'd0;
                trk_vld_next = 1'b1;
            end
            default:
            begin
                trk_next     = trk_reg;
                trk_vld_next = trk_vld_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            trk_reg       <= 7'd0;
            trk_vld_reg   <= 1'b0;
        end
        else
        begin
            if (req_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                trk_reg       <= trk_next;
                trk_vld_reg   <= trk_vld_next;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_reg          <= req;
            s1_blk_ok_reg   <= blk_ok_in;
            s1_icn_ok_reg   <= icn_ok_in;
            s1_byp_reg      <= byp_next;
            s1_byp_data_reg <= byp_data_next;
        end
        if (s1_adv)
        begin
            out_reg <= rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef ASSERT_OFF
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (s1_valid_reg && rsp_valid && !rsp_ready))
        else $error("request stalled without a stalled response");

    a_icon_restores: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.page == ICON_PAGE) |->
            (rsp.send && rsp.cursor_cmd && rsp.restore_cursor))
        else $error("icon response without cursor restore");

    a_idle_rsp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.send) |->
            (!rsp.cursor_cmd && !rsp.restore_cursor && rsp.column_bytes == 64'd0))
        else $error("unsent response carries data");

    a_single_shadow_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(blk_wr_en && icn_wr_en))
        else $error("both shadow stores written in one cycle");
`endif

endmodule
`default_nettype wire
